[rtl/uart_ring_buffer_pair_core_assert.svh]
// assertion macros shared by the uart ring buffer pair rtl
`ifndef UART_RING_BUFFER_PAIR_CORE_ASSERT_SVH
`define UART_RING_BUFFER_PAIR_CORE_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define URBP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define URBP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/urbp_pkg.sv]
// shared types and constants for the uart ring buffer pair
package urbp_pkg;

   localparam int BYTE_W        = 8;
   localparam int REQ_TYPE_W    = 3;
   localparam int RX_COUNT_W    = 6;
   localparam int TX_FREE_W     = 3;
   localparam int RX_DEPTH_DEF  = 64;
   localparam int TX_DEPTH_DEF  = 8;

   // request codes; the unused code falls through as a status query
   typedef enum logic [REQ_TYPE_W-1:0] {
      OP_LINE_RX   = 3'd0,
      OP_TX_DONE   = 3'd1,
      OP_HOST_READ = 3'd2,
      OP_HOST_SEND = 3'd3,
      OP_RX_FLUSH  = 3'd4,
      OP_TX_FLUSH  = 3'd5,
      OP_STATUS    = 3'd6
   } op_type;

   // per-beat command to one ring
   typedef struct packed {
      logic push;      // write a byte at the write pointer
      logic pop;       // take the head byte, advance read pointer
      logic flush_rd;  // read pointer jumps to write pointer
      logic flush_wr;  // write pointer drops back to read pointer, clears overflow
   } ring_cmd_type;

endpackage

[rtl/urbp_ram.sv]
// generic single write port ram with registered read
module urbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/urbp_ring.sv]
// one circular byte buffer: pointers, overflow flag, storage and head prefetch
module urbp_ring #(
   parameter int DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  urbp_pkg::ring_cmd_type       cmd,
   input  logic [urbp_pkg::BYTE_W-1:0]  push_data,
   output logic [urbp_pkg::BYTE_W-1:0]  head_data,
   output logic                         empty,
   output logic [$clog2(DEPTH)-1:0]     level,
   output logic                         over_flag
);
   import urbp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [PTR_W:0]   DEPTH_W  = (PTR_W + 1)'(DEPTH);

   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic              over_ff, over_in;
   logic [PTR_W-1:0]  wr_nxt, rd_nxt;
   logic [PTR_W:0]    level_wide;
   logic [DEPTH-1:0]  valid_ff;
   logic              head_valid_ff;
   logic              head_fwd_ff;
   logic [BYTE_W-1:0] fwd_data_ff;
   logic [BYTE_W-1:0] ram_q;

   // pointer increment with wrap at the depth
   assign wr_nxt = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_nxt = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   // next pointer and flag state
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      over_in   = over_ff;
      if (cmd.push) begin
         wr_ptr_in = wr_nxt;
         if (wr_nxt == rd_ptr_ff) begin
            over_in = 1'b1;
         end
      end
      if (cmd.pop) begin
         rd_ptr_in = rd_nxt;
      end
      if (cmd.flush_rd) begin
         rd_ptr_in = wr_ptr_ff;
      end
      if (cmd.flush_wr) begin
         wr_ptr_in = rd_ptr_ff;
         over_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         over_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         over_ff   <= over_in;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.push) begin
         valid_ff[wr_ptr_ff] <= 1'b1;
      end
   end

   // storage, read address follows the next read pointer so the head is ready
   urbp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_data),
      .rd_addr (rd_ptr_in),
      .rd_data (ram_q)
   );

   // head prefetch with forward of a same-cycle write to the head entry
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         head_fwd_ff   <= 1'b0;
      end else begin
         head_valid_ff <= valid_ff[rd_ptr_in];
         head_fwd_ff   <= cmd.push && (wr_ptr_ff == rd_ptr_in);
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= push_data;
   end

   assign head_data = head_fwd_ff   ? fwd_data_ff :
                      head_valid_ff ? ram_q       : '0;

   // status: level and overflow after this beat, empty from the current pointers
   assign level_wide = (wr_ptr_in >= rd_ptr_in) ?
                       ({1'b0, wr_ptr_in} - {1'b0, rd_ptr_in}) :
                       ({1'b0, wr_ptr_in} + DEPTH_W - {1'b0, rd_ptr_in});
   assign level      = level_wide[PTR_W-1:0];
   assign empty      = (wr_ptr_ff == rd_ptr_ff);
   assign over_flag  = over_in;

endmodule

[rtl/uart_ring_buffer_pair_core.sv]
// uart receive and transmit ring buffer pair, top level
// response: registered, valid in the cycle after an accepted request beat
// throughput: one request per cycle while responses are taken; each beat touches
//    at most one ring entry, with the head prefetched via the registered ram read port
// reset: synchronous, clears pointers, flags and the entry valid bits, so all
//    entries read as zero; no clearing sweep, requests are taken right after

module uart_ring_buffer_pair_core #(
   parameter int RX_DEPTH = urbp_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = urbp_pkg::TX_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [urbp_pkg::REQ_TYPE_W-1:0]  req_type,
   input  logic [urbp_pkg::BYTE_W-1:0]      req_data_in,
   input  logic                             req_line_idle,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [urbp_pkg::BYTE_W-1:0]      rsp_read_data,
   output logic                             rsp_line_out_valid,
   output logic [urbp_pkg::BYTE_W-1:0]      rsp_line_out_byte,
   output logic [urbp_pkg::RX_COUNT_W-1:0]  rsp_rx_count,
   output logic [urbp_pkg::TX_FREE_W-1:0]   rsp_tx_free,
   output logic                             rsp_rx_overflow,
   output logic                             rsp_tx_overflow
);
   import urbp_pkg::*;

   `include "uart_ring_buffer_pair_core_assert.svh"

   localparam int RX_PW = $clog2(RX_DEPTH);
   localparam int TX_PW = $clog2(TX_DEPTH);
   localparam logic [TX_PW-1:0] TX_LAST = TX_PW'(TX_DEPTH - 1);

   logic              accept;
   ring_cmd_type      rx_cmd, tx_cmd;
   logic [BYTE_W-1:0] rx_head, tx_head;
   logic              rx_empty, tx_empty;
   logic [RX_PW-1:0]  rx_level;
   logic [TX_PW-1:0]  tx_level;
   logic              rx_over, tx_over;
   logic [TX_PW-1:0]  tx_free_full;

   logic [BYTE_W-1:0]     read_data_in;
   logic                  line_valid_in;
   logic [BYTE_W-1:0]     line_byte_in;

   logic                  rsp_valid_ff;
   logic [BYTE_W-1:0]     read_data_ff;
   logic                  line_valid_ff;
   logic [BYTE_W-1:0]     line_byte_ff;
   logic [RX_COUNT_W-1:0] rx_count_ff;
   logic [TX_FREE_W-1:0]  tx_free_ff;
   logic                  rx_over_ff;
   logic                  tx_over_ff;

   // handshake: the response register frees up when its beat is taken
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // decode the request into ring commands and response bytes
   always_comb begin
      rx_cmd        = '0;
      tx_cmd        = '0;
      read_data_in  = '0;
      line_valid_in = 1'b0;
      line_byte_in  = '0;
      if (accept) begin
         unique case (req_type)
            OP_LINE_RX: begin
               rx_cmd.push = 1'b1;
            end
            OP_TX_DONE: begin
               if (!tx_empty) begin
                  tx_cmd.pop    = 1'b1;
                  line_valid_in = 1'b1;
                  line_byte_in  = tx_head;
               end
            end
            OP_HOST_READ: begin
               rx_cmd.pop   = 1'b1;
               read_data_in = rx_head;
            end
            OP_HOST_SEND: begin
               // empty ring and idle line: byte bypasses the ring
               if (tx_empty && req_line_idle) begin
                  line_valid_in = 1'b1;
                  line_byte_in  = req_data_in;
               end else begin
                  tx_cmd.push = 1'b1;
               end
            end
            OP_RX_FLUSH: begin
               rx_cmd.flush_rd = 1'b1;
            end
            OP_TX_FLUSH: begin
               tx_cmd.flush_wr = 1'b1;
            end
            default: begin
               // status query and the unused code change nothing
            end
         endcase
      end
   end

   // receive ring
   urbp_ring #(
      .DEPTH (RX_DEPTH)
   ) u_rx_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (rx_cmd),
      .push_data (req_data_in),
      .head_data (rx_head),
      .empty     (rx_empty),
      .level     (rx_level),
      .over_flag (rx_over)
   );

   // transmit ring
   urbp_ring #(
      .DEPTH (TX_DEPTH)
   ) u_tx_ring (
      .clock     (clock),
      .reset     (reset),
      .cmd       (tx_cmd),
      .push_data (req_data_in),
      .head_data (tx_head),
      .empty     (tx_empty),
      .level     (tx_level),
      .over_flag (tx_over)
   );

   // free places are depth minus one minus the fill level
   assign tx_free_full = TX_LAST - tx_level;

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff  <= read_data_in;
         line_valid_ff <= line_valid_in;
         line_byte_ff  <= line_byte_in;
         rx_count_ff   <= RX_COUNT_W'(rx_level);
         tx_free_ff    <= TX_FREE_W'(tx_free_full);
         rx_over_ff    <= rx_over;
         tx_over_ff    <= tx_over;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = read_data_ff;
   assign rsp_line_out_valid = line_valid_ff;
   assign rsp_line_out_byte  = line_byte_ff;
   assign rsp_rx_count       = rx_count_ff;
   assign rsp_tx_free        = tx_free_ff;
   assign rsp_rx_overflow    = rx_over_ff;
   assign rsp_tx_overflow    = tx_over_ff;

   // checks
   `URBP_ASSERT_NEXT(a_tx_done_drains, accept && (req_type == OP_TX_DONE) && !tx_empty,
      rsp_valid && rsp_line_out_valid, "tx done on a filled ring handed no byte to the line")
   `URBP_ASSERT_NEXT(a_read_data_zero, accept && (req_type != OP_HOST_READ),
      rsp_valid && (rsp_read_data == '0), "read data nonzero on a beat that is not a host read")
   `URBP_ASSERT_NEXT(a_rx_over_sticky, rx_over, rx_over, "receive overflow flag dropped")
   `URBP_ASSERT_NEXT(a_tx_flush_clears, accept && (req_type == OP_TX_FLUSH),
      !rsp_tx_overflow && tx_empty, "tx flush left the ring filled or the flag set")
   `URBP_ASSERT_NEXT(a_rx_flush_empties, accept && (req_type == OP_RX_FLUSH),
      rx_empty && (rsp_rx_count == '0), "rx flush left bytes in the receive ring")
   `URBP_ASSERT_NOW(a_no_cmd_idle, !accept,
      (rx_cmd == '0) && (tx_cmd == '0), "ring command issued without an accepted beat")

endmodule

[tb/uart_ring_buffer_pair_core_test.sv]
// self-checking testbench for the uart receive and transmit ring buffer pair
module uart_ring_buffer_pair_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import urbp_pkg::*;

   localparam int RX_DEPTH = RX_DEPTH_DEF;
   localparam int TX_DEPTH = TX_DEPTH_DEF;
   localparam int RANDOM_REQS = 1050;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   // request code outside the enum, handled as a status query
   localparam logic [REQ_TYPE_W-1:0] OP_UNUSED = 3'd7;

   typedef struct {
      logic [REQ_TYPE_W-1:0] op;
      logic [BYTE_W-1:0]     data;
      logic                  idle;
      int                    gap;
   } ring_req_type;

   typedef struct {
      logic [BYTE_W-1:0]     read_data;
      logic                  line_out_valid;
      logic [BYTE_W-1:0]     line_out_byte;
      logic [RX_COUNT_W-1:0] rx_count;
      logic [TX_FREE_W-1:0]  tx_free;
      logic                  rx_overflow;
      logic                  tx_overflow;
   } ring_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [REQ_TYPE_W-1:0] req_type = '0;
   logic [BYTE_W-1:0] req_data_in = '0;
   logic req_line_idle = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [BYTE_W-1:0] rsp_read_data;
   logic rsp_line_out_valid;
   logic [BYTE_W-1:0] rsp_line_out_byte;
   logic [RX_COUNT_W-1:0] rsp_rx_count;
   logic [TX_FREE_W-1:0] rsp_tx_free;
   logic rsp_rx_overflow;
   logic rsp_tx_overflow;

   ring_req_type    req_backlog[$];
   ring_status_type ring_results_due[$];
   int              mismatches = 0;
   int              cycles = 0;
   bit              quiet_send = 1'b0;
   bit              quiet_recv = 1'b0;

   // shadow copy of both rings
   bit [BYTE_W-1:0] rx_mem [RX_DEPTH];
   bit [BYTE_W-1:0] tx_mem [TX_DEPTH];
   int rx_wr = 0, rx_rd = 0, tx_wr = 0, tx_rd = 0;
   bit rx_over = 1'b0, tx_over = 1'b0;

   uart_ring_buffer_pair_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_data_in        (req_data_in),
      .req_line_idle      (req_line_idle),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_read_data      (rsp_read_data),
      .rsp_line_out_valid (rsp_line_out_valid),
      .rsp_line_out_byte  (rsp_line_out_byte),
      .rsp_rx_count       (rsp_rx_count),
      .rsp_tx_free        (rsp_tx_free),
      .rsp_rx_overflow    (rsp_rx_overflow),
      .rsp_tx_overflow    (rsp_tx_overflow)
   );

   // clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // advance the shadow rings by one request and queue the status it yields
   task automatic step_rings(input logic [REQ_TYPE_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input logic idle);
      ring_status_type st;
      st = '{default: '0};
      case (op)
         OP_LINE_RX: begin
            rx_mem[rx_wr] = data;
            rx_wr = (rx_wr + 1) % RX_DEPTH;
            if (rx_wr == rx_rd) rx_over = 1'b1;
         end
         OP_TX_DONE: begin
            if (tx_wr != tx_rd) begin
               st.line_out_valid = 1'b1;
               st.line_out_byte = tx_mem[tx_rd];
               tx_rd = (tx_rd + 1) % TX_DEPTH;
            end
         end
         OP_HOST_READ: begin
            // no empty check: an empty ring hands out a stale entry
            st.read_data = rx_mem[rx_rd];
            rx_rd = (rx_rd + 1) % RX_DEPTH;
         end
         OP_HOST_SEND: begin
            if (tx_wr == tx_rd && idle) begin
               // empty ring and idle line: straight to the line
               st.line_out_valid = 1'b1;
               st.line_out_byte = data;
            end else begin
               tx_mem[tx_wr] = data;
               tx_wr = (tx_wr + 1) % TX_DEPTH;
               if (tx_wr == tx_rd) tx_over = 1'b1;
            end
         end
         OP_RX_FLUSH: rx_rd = rx_wr;
         OP_TX_FLUSH: begin
            tx_wr = tx_rd;
            tx_over = 1'b0;
         end
         default: ;
      endcase
      st.rx_count = RX_COUNT_W'((rx_wr + RX_DEPTH - rx_rd) % RX_DEPTH);
      st.tx_free = TX_FREE_W'((tx_rd + 2 * TX_DEPTH - tx_wr - 1) % TX_DEPTH);
      st.rx_overflow = rx_over;
      st.tx_overflow = tx_over;
      ring_results_due.push_back(st);
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, expected, actual);
         mismatches++;
      end
   endtask

   task automatic add_req(input logic [REQ_TYPE_W-1:0] op, input logic [BYTE_W-1:0] data,
                          input logic idle);
      ring_req_type r;
      r.op = op;
      r.data = data;
      r.idle = idle;
      r.gap = quiet_send ? 0 : $urandom_range(0, 16);
      req_backlog.push_back(r);
   endtask

   // request driver: takes items from the backlog, idles by each item's gap
   ring_req_type staged_req;
   bit           staged = 1'b0;
   int           hold = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) step_rings(req_type, req_data_in, req_line_idle);
         if (!req_valid || req_ready) begin
            if (!staged && req_backlog.size() > 0) begin
               staged_req = req_backlog.pop_front();
               staged = 1'b1;
               hold = staged_req.gap;
            end
            if (staged && hold == 0) begin
               req_valid <= 1'b1;
               req_type <= staged_req.op;
               req_data_in <= staged_req.data;
               req_line_idle <= staged_req.idle;
               staged = 1'b0;
            end else begin
               req_valid <= 1'b0;
               if (staged) hold--;
            end
         end
      end
   end

   // response monitor: checks each beat, then holds rsp_ready low for a random stall
   int stall = 0;
   int rsp_beats = 0;

   always @(posedge clock) begin
      ring_status_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ring_results_due.size() == 0) begin
               $display("%0t: response beat with nothing expected, rx_count %0h", $time,
                        rsp_rx_count);
               mismatches++;
            end else begin
               due = ring_results_due.pop_front();
               check_field("read_data", due.read_data, rsp_read_data);
               check_field("line_out_valid", due.line_out_valid, rsp_line_out_valid);
               check_field("line_out_byte", due.line_out_byte, rsp_line_out_byte);
               check_field("rx_count", due.rx_count, rsp_rx_count);
               check_field("tx_free", due.tx_free, rsp_tx_free);
               check_field("rx_overflow", due.rx_overflow, rsp_rx_overflow);
               check_field("tx_overflow", due.tx_overflow, rsp_tx_overflow);
            end
            rsp_beats++;
            if (rsp_beats % 32 == 0) quiet_recv = ($urandom_range(0, 3) == 0);
            stall = quiet_recv ? 0 : $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // run time guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("uart_ring_buffer_pair_core_test NOT OK");
         $finish;
      end
   end

   // stimulus and end of test
   initial begin
      int pick;
      int bias;
      logic [REQ_TYPE_W-1:0] op;
      logic idle;

      // status, unused code, tx done on empty ring
      add_req(OP_STATUS, 8'h00, 1'b0);
      add_req(OP_UNUSED, 8'hFF, 1'b1);
      add_req(OP_TX_DONE, 8'h00, 1'b1);
      // bypass to line, then queued sends
      add_req(OP_HOST_SEND, 8'hFF, 1'b1);
      add_req(OP_HOST_SEND, 8'h00, 1'b0);
      add_req(OP_HOST_SEND, 8'hA5, 1'b1);
      add_req(OP_TX_DONE, 8'h00, 1'b0);
      add_req(OP_TX_DONE, 8'hFF, 1'b1);
      // receive path and flush
      add_req(OP_LINE_RX, 8'hFF, 1'b0);
      add_req(OP_LINE_RX, 8'h00, 1'b1);
      add_req(OP_HOST_READ, 8'h00, 1'b0);
      add_req(OP_RX_FLUSH, 8'h00, 1'b0);
      // fill the tx ring until it overflows, then flush it
      repeat (TX_DEPTH) add_req(OP_HOST_SEND, 8'($urandom_range(0, 255)), 1'b0);
      add_req(OP_TX_FLUSH, 8'h00, 1'b0);
      // read from empty ring, then one line byte overflows the rx ring
      add_req(OP_HOST_READ, 8'h00, 1'b1);
      add_req(OP_LINE_RX, 8'h5A, 1'b0);
      add_req(OP_HOST_READ, 8'h00, 1'b0);
      add_req(OP_TX_FLUSH, 8'h00, 1'b1);

      // random traffic in phases: balanced, filling, draining
      bias = 0;
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 40 == 0) begin
            bias = $urandom_range(0, 2);
            quiet_send = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         case (bias)
            1: op = (pick < 40) ? OP_LINE_RX : (pick < 48) ? OP_TX_DONE :
                    (pick < 56) ? OP_HOST_READ : (pick < 92) ? OP_HOST_SEND :
                    (pick < 94) ? OP_RX_FLUSH : (pick < 96) ? OP_TX_FLUSH :
                    (pick < 98) ? OP_STATUS : OP_UNUSED;
            2: op = (pick < 12) ? OP_LINE_RX : (pick < 45) ? OP_TX_DONE :
                    (pick < 80) ? OP_HOST_READ : (pick < 90) ? OP_HOST_SEND :
                    (pick < 93) ? OP_RX_FLUSH : (pick < 96) ? OP_TX_FLUSH :
                    (pick < 98) ? OP_STATUS : OP_UNUSED;
            default: op = (pick < 22) ? OP_LINE_RX : (pick < 42) ? OP_TX_DONE :
                    (pick < 62) ? OP_HOST_READ : (pick < 84) ? OP_HOST_SEND :
                    (pick < 87) ? OP_RX_FLUSH : (pick < 90) ? OP_TX_FLUSH :
                    (pick < 96) ? OP_STATUS : OP_UNUSED;
         endcase
         // a busy line keeps sends in the ring while filling
         idle = (bias == 1) ? ($urandom_range(0, 4) == 0) : 1'($urandom_range(0, 1));
         add_req(op, 8'($urandom_range(0, 255)), idle);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() > 0 || staged || req_valid || ring_results_due.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("uart_ring_buffer_pair_core_test OK");
      else
         $display("uart_ring_buffer_pair_core_test NOT OK");
      $finish;
   end

endmodule
